### hw/rtl/ffha_pkg.sv
// ffha_pkg: sizes, operation codes and table entry layouts of the heap allocator
// shared by the allocator top level and its checker; depends on nothing
package ffha_pkg;

	localparam int MAX_USED     = 64;
	localparam int MAX_FREE     = 65;
	localparam int HEADER_BYTES = 16;
	localparam int ADDR_BITS    = 20;

	localparam int SIZE_W   = ADDR_BITS + 1;
	localparam int NEED_W   = SIZE_W + 1;
	localparam int OWNER_W  = 8;
	localparam int OP_W     = 2;
	localparam int FIDX_W   = $clog2(MAX_FREE);
	localparam int UIDX_W   = $clog2(MAX_USED);
	localparam int CNT_W    = $clog2(MAX_FREE + 1);
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W    = SIZE_W;

	localparam int FREE_W = ADDR_BITS + SIZE_W;
	localparam int USED_W = ADDR_BITS + SIZE_W + OWNER_W;

	localparam int MIN_TAIL   = 4;
	localparam int ALIGN_MASK = 3;

	localparam logic [SIZE_W-1:0] HEAP_MIN   = SIZE_W'(64);
	localparam logic [SIZE_W-1:0] HEAP_MAX   = SIZE_W'(1048576);
	localparam logic [SIZE_W-1:0] HEAP_RESET = SIZE_W'(32768);

	localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
	localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd2;
	localparam logic [OP_W-1:0] OP_COUNT = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_HEAP_BYTES   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_READY = 1'd1;

endpackage

### hw/rtl/ffha_ram.sv
// ffha_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module ffha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### hw/rtl/first_fit_heap_allocator_unit.sv
// first_fit_heap_allocator_unit: first-fit heap allocator with free block coalescing
// uses ffha_pkg and two ffha_ram instances (free table, allocated table)
//
// channel | signals                                              | direction
// in      | in_valid in_ready operation req_size block_address   | request
//         | address_is_null task_id                              |
// out     | out_valid out_ready status payload_address           | result
//         | small_block_count                                    |
// cfg     | cfg_valid cfg_ready cfg_index cfg_data               | register write
//
// init writes one free entry; allocate scans free entries and may move entries down
// free: searches allocated entries, scans free entries and may move entries up or down
// count walks the free entries; every walk goes through the single read port of a table
// in_ready is high only between transactions; a result waits in the output register
// reset is asynchronous; table memories need no clearing pass, cfg_ready is always high
module first_fit_heap_allocator_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [ffha_pkg::OP_W-1:0]         operation,
	input  logic [ffha_pkg::SIZE_W-1:0]       req_size,
	input  logic [ffha_pkg::ADDR_BITS-1:0]    block_address,
	input  logic                              address_is_null,
	input  logic [ffha_pkg::OWNER_W-1:0]      task_id,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              status,
	output logic [ffha_pkg::ADDR_BITS-1:0]    payload_address,
	output logic [ffha_pkg::CNT_W-1:0]        small_block_count,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ffha_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ffha_pkg::CFG_W-1:0]        cfg_data
);
	import ffha_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE, ST_INIT_WR, ST_A_RD, ST_A_EV, ST_RM_RD, ST_RM_WR,
		ST_F_URD, ST_F_UEV, ST_F_RD, ST_F_EV, ST_F_ACT, ST_UP_RD, ST_UP_WR,
		ST_C_RD, ST_C_EV, ST_DONE
	} state_t;

	state_t state_q;

	logic [SIZE_W-1:0]    heap_bytes_q;
	logic                 kernel_ready_q;
	logic                 heap_ready_q;
	logic [CNT_W-1:0]     free_count_q;
	logic [MAX_USED-1:0]  used_valid_q;

	logic [NEED_W-1:0]    need_q;
	logic [SIZE_W-1:0]    req_q;
	logic [ADDR_BITS-1:0] s_q;
	logic [OWNER_W-1:0]   task_q;
	logic [CNT_W-1:0]     idx_q;
	logic [CNT_W-1:0]     k_q;
	logic [UIDX_W-1:0]    uidx_q;
	logic [UIDX_W-1:0]    slot_q;
	logic [SIZE_W-1:0]    z_q;
	logic                 has_prev_q;
	logic [ADDR_BITS-1:0] prev_start_q;
	logic [SIZE_W-1:0]    prev_size_q;
	logic                 nxt_found_q;
	logic [ADDR_BITS-1:0] nxt_start_q;
	logic [SIZE_W-1:0]    nxt_size_q;

	logic                 res_status_q;
	logic [ADDR_BITS-1:0] res_pay_q;
	logic [CNT_W-1:0]     res_cnt_q;

	logic                 out_valid_q;
	logic                 status_q;
	logic [ADDR_BITS-1:0] payload_address_q;
	logic [CNT_W-1:0]     small_block_count_q;

	// table ports
	logic                 f_we;
	logic [FIDX_W-1:0]    f_waddr, f_raddr;
	logic [FREE_W-1:0]    f_wdata, f_rdata;
	logic                 u_we;
	logic [USED_W-1:0]    u_wdata, u_rdata;

	ffha_ram #(.WIDTH(FREE_W), .DEPTH(MAX_FREE)) u_free_ram (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
		.raddr(f_raddr), .rdata(f_rdata)
	);

	ffha_ram #(.WIDTH(USED_W), .DEPTH(MAX_USED)) u_used_ram (
		.clk(clk), .we(u_we), .waddr(slot_q), .wdata(u_wdata),
		.raddr(uidx_q), .rdata(u_rdata)
	);

	logic [ADDR_BITS-1:0] fr_start;
	logic [SIZE_W-1:0]    fr_size;
	logic [ADDR_BITS-1:0] ur_start;
	logic [SIZE_W-1:0]    ur_size;
	logic [OWNER_W-1:0]   ur_owner;
	assign fr_start = f_rdata[FREE_W-1 -: ADDR_BITS];
	assign fr_size  = f_rdata[SIZE_W-1:0];
	assign ur_start = u_rdata[USED_W-1 -: ADDR_BITS];
	assign ur_size  = u_rdata[OWNER_W +: SIZE_W];
	assign ur_owner = u_rdata[OWNER_W-1:0];

	logic                 fit;
	logic [NEED_W-1:0]    rem;
	logic                 split;
	logic                 mnext, mprev;
	logic [NEED_W-1:0]    s_plus_z, prev_end;
	logic [SIZE_W-1:0]    hb_clamp;
	logic [UIDX_W-1:0]    first_slot;
	logic [NEED_W-1:0]    need_in;

	assign fit      = {1'b0, fr_size} >= need_q;
	assign rem      = {1'b0, fr_size} - need_q;
	assign split    = rem >= NEED_W'(HEADER_BYTES + MIN_TAIL);
	assign s_plus_z = NEED_W'(s_q) + NEED_W'(z_q);
	assign prev_end = NEED_W'(prev_start_q) + NEED_W'(prev_size_q);
	assign mnext    = nxt_found_q && (s_plus_z == NEED_W'(nxt_start_q));
	assign mprev    = has_prev_q && (prev_end == NEED_W'(s_q));
	assign hb_clamp = (heap_bytes_q < HEAP_MIN) ? HEAP_MIN :
			(heap_bytes_q > HEAP_MAX) ? HEAP_MAX : heap_bytes_q;
	assign need_in  = ((NEED_W'(req_size) + NEED_W'(ALIGN_MASK)) & ~NEED_W'(ALIGN_MASK))
			+ NEED_W'(HEADER_BYTES);

	always_comb begin
		first_slot = '0;
		for (int j = MAX_USED - 1; j >= 0; j--) begin
			if (!used_valid_q[j]) begin
				first_slot = UIDX_W'(j);
			end
		end
	end

	always_comb begin
		f_we    = 1'b0;
		f_waddr = idx_q[FIDX_W-1:0];
		f_wdata = f_rdata;
		f_raddr = idx_q[FIDX_W-1:0];
		u_we    = 1'b0;
		u_wdata = {fr_start, fr_size, task_q};
		case (state_q)
			ST_INIT_WR: begin
				f_we    = 1'b1;
				f_waddr = '0;
				f_wdata = {ADDR_BITS'(0), hb_clamp};
			end
			ST_A_EV: begin
				if (fit) begin
					u_we = 1'b1;
					if (split) begin
						u_wdata = {fr_start, need_q[SIZE_W-1:0], task_q};
						f_we    = 1'b1;
						f_wdata = {fr_start + need_q[ADDR_BITS-1:0], rem[SIZE_W-1:0]};
					end
				end
			end
			ST_RM_RD: f_raddr = FIDX_W'(k_q + 1'b1);
			ST_RM_WR: begin
				f_we    = 1'b1;
				f_waddr = k_q[FIDX_W-1:0];
			end
			ST_F_ACT: begin
				if (mprev) begin
					f_we    = 1'b1;
					f_waddr = FIDX_W'(idx_q - 1'b1);
					f_wdata = mnext ? {prev_start_q, prev_size_q + z_q + nxt_size_q}
							: {prev_start_q, prev_size_q + z_q};
				end else if (mnext) begin
					f_we    = 1'b1;
					f_wdata = {s_q, nxt_size_q + z_q};
				end
			end
			ST_UP_RD: begin
				f_raddr = FIDX_W'(k_q - 1'b1);
				if (k_q == idx_q) begin
					f_we    = 1'b1;
					f_wdata = {s_q, z_q};
				end
			end
			ST_UP_WR: begin
				f_we    = 1'b1;
				f_waddr = k_q[FIDX_W-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q             <= ST_IDLE;
			heap_bytes_q        <= HEAP_RESET;
			kernel_ready_q      <= 1'b0;
			heap_ready_q        <= 1'b0;
			free_count_q        <= '0;
			used_valid_q        <= '0;
			need_q              <= '0;
			req_q               <= '0;
			s_q                 <= '0;
			task_q              <= '0;
			idx_q               <= '0;
			k_q                 <= '0;
			uidx_q              <= '0;
			slot_q              <= '0;
			z_q                 <= '0;
			has_prev_q          <= 1'b0;
			prev_start_q        <= '0;
			prev_size_q         <= '0;
			nxt_found_q         <= 1'b0;
			nxt_start_q         <= '0;
			nxt_size_q          <= '0;
			res_status_q        <= 1'b0;
			res_pay_q           <= '0;
			res_cnt_q           <= '0;
			out_valid_q         <= 1'b0;
			status_q            <= 1'b0;
			payload_address_q   <= '0;
			small_block_count_q <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_HEAP_BYTES:   heap_bytes_q   <= cfg_data;
					REG_KERNEL_READY: kernel_ready_q <= cfg_data[0];
					default: ;
				endcase
			end
			// in ST_DONE the output register is reloaded instead
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						need_q       <= need_in;
						req_q        <= req_size;
						task_q       <= task_id;
						s_q          <= block_address - ADDR_BITS'(HEADER_BYTES);
						idx_q        <= '0;
						uidx_q       <= '0;
						slot_q       <= first_slot;
						has_prev_q   <= 1'b0;
						nxt_found_q  <= 1'b0;
						res_status_q <= 1'b1;
						res_pay_q    <= '0;
						res_cnt_q    <= '0;
						state_q      <= ST_DONE;
						case (operation)
							OP_INIT: begin
								if (kernel_ready_q && !heap_ready_q) begin
									res_status_q <= 1'b0;
									state_q      <= ST_INIT_WR;
								end
							end
							OP_ALLOC: begin
								if (heap_ready_q && req_size != '0 && !(&used_valid_q)) begin
									state_q <= ST_A_RD;
								end
							end
							OP_FREE: begin
								if (address_is_null) begin
									res_status_q <= 1'b0;
								end else if (heap_ready_q &&
										block_address >= ADDR_BITS'(HEADER_BYTES)) begin
									state_q <= ST_F_URD;
								end
							end
							OP_COUNT: begin
								res_status_q <= 1'b0;
								if (heap_ready_q) begin
									state_q <= ST_C_RD;
								end
							end
							default: ;
						endcase
					end
				end
				ST_INIT_WR: begin
					free_count_q <= CNT_W'(1);
					heap_ready_q <= 1'b1;
					state_q      <= ST_DONE;
				end
				ST_A_RD: begin
					state_q <= (idx_q == free_count_q) ? ST_DONE : ST_A_EV;
				end
				ST_A_EV: begin
					if (fit) begin
						used_valid_q[slot_q] <= 1'b1;
						res_status_q         <= 1'b0;
						res_pay_q            <= fr_start + ADDR_BITS'(HEADER_BYTES);
						if (split) begin
							state_q <= ST_DONE;
						end else begin
							k_q     <= idx_q;
							state_q <= ST_RM_RD;
						end
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_A_RD;
					end
				end
				// close the gap at k_q by moving later entries down
				ST_RM_RD: begin
					if (k_q + 1'b1 >= free_count_q) begin
						free_count_q <= free_count_q - 1'b1;
						state_q      <= ST_DONE;
					end else begin
						state_q <= ST_RM_WR;
					end
				end
				ST_RM_WR: begin
					k_q     <= k_q + 1'b1;
					state_q <= ST_RM_RD;
				end
				ST_F_URD: begin
					if (used_valid_q[uidx_q]) begin
						state_q <= ST_F_UEV;
					end else if (uidx_q == UIDX_W'(MAX_USED - 1)) begin
						state_q <= ST_DONE;
					end else begin
						uidx_q <= uidx_q + 1'b1;
					end
				end
				ST_F_UEV: begin
					if (ur_start == s_q) begin
						if (ur_owner != task_q) begin
							state_q <= ST_DONE;
						end else begin
							z_q     <= ur_size;
							slot_q  <= uidx_q;
							state_q <= ST_F_RD;
						end
					end else if (uidx_q == UIDX_W'(MAX_USED - 1)) begin
						state_q <= ST_DONE;
					end else begin
						uidx_q  <= uidx_q + 1'b1;
						state_q <= ST_F_URD;
					end
				end
				ST_F_RD: begin
					state_q <= (idx_q == free_count_q) ? ST_F_ACT : ST_F_EV;
				end
				ST_F_EV: begin
					if (fr_start > s_q) begin
						nxt_found_q <= 1'b1;
						nxt_start_q <= fr_start;
						nxt_size_q  <= fr_size;
						state_q     <= ST_F_ACT;
					end else begin
						has_prev_q   <= 1'b1;
						prev_start_q <= fr_start;
						prev_size_q  <= fr_size;
						idx_q        <= idx_q + 1'b1;
						state_q      <= ST_F_RD;
					end
				end
				ST_F_ACT: begin
					if (!mnext && !mprev && free_count_q >= CNT_W'(MAX_FREE)) begin
						state_q <= ST_DONE;
					end else begin
						used_valid_q[slot_q] <= 1'b0;
						res_status_q         <= 1'b0;
						if (mnext && mprev) begin
							k_q     <= idx_q;
							state_q <= ST_RM_RD;
						end else if (mnext || mprev) begin
							state_q <= ST_DONE;
						end else begin
							k_q     <= free_count_q;
							state_q <= ST_UP_RD;
						end
					end
				end
				// open a gap at idx_q by moving entries up from the end
				ST_UP_RD: begin
					if (k_q == idx_q) begin
						free_count_q <= free_count_q + 1'b1;
						state_q      <= ST_DONE;
					end else begin
						state_q <= ST_UP_WR;
					end
				end
				ST_UP_WR: begin
					k_q     <= k_q - 1'b1;
					state_q <= ST_UP_RD;
				end
				ST_C_RD: begin
					state_q <= (idx_q == free_count_q) ? ST_DONE : ST_C_EV;
				end
				ST_C_EV: begin
					if (fr_size < req_q) begin
						res_cnt_q <= res_cnt_q + 1'b1;
					end
					idx_q   <= idx_q + 1'b1;
					state_q <= ST_C_RD;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q         <= 1'b1;
						status_q            <= res_status_q;
						payload_address_q   <= res_pay_q;
						small_block_count_q <= res_cnt_q;
						state_q             <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready          = (state_q == ST_IDLE);
	assign cfg_ready         = 1'b1;
	assign out_valid         = out_valid_q;
	assign status            = status_q;
	assign payload_address   = payload_address_q;
	assign small_block_count = small_block_count_q;
endmodule

### hw/rtl/ffha_checker.sv
// ffha_checker: port-level assertions for the heap allocator, bound to the top level
// uses ffha_pkg
module ffha_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic                              status,
	input logic [ffha_pkg::ADDR_BITS-1:0]    payload_address,
	input logic [ffha_pkg::CNT_W-1:0]        small_block_count
);
	import ffha_pkg::*;

	// one transaction at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready high right after an accepted transaction");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(payload_address) && $stable(status))
		else $error("result dropped or changed while stalled");

	a_addr_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && payload_address != '0 |-> !status &&
			payload_address >= ADDR_BITS'(HEADER_BYTES) && small_block_count == '0)
		else $error("payload address on a failed or non-allocate result");

	a_count_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && small_block_count != '0 |-> !status &&
			small_block_count <= CNT_W'(MAX_FREE))
		else $error("bad small block count");
endmodule

bind first_fit_heap_allocator_unit ffha_checker u_ffha_checker (.*);
